@@ hw/rtl/spa_pkg.sv @@
package spa_pkg;

   // Request codes.
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_FREE   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_MISSING = 2'd2;

   // Register indexes on the control port.
   localparam logic CSR_RANGE_LOW  = 1'b0;
   localparam logic CSR_RANGE_HIGH = 1'b1;

   // Reset values of the range registers.
   localparam logic [15:0] RANGE_LOW_RESET  = 16'd0;
   localparam logic [15:0] RANGE_HIGH_RESET = 16'd63;

   // Slots per word of the occupancy bitmap memory.
   localparam int WORD_BITS = 32;
   localparam int BIT_IDX_W = 5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] peer_port;
      logic [15:0] bound_port;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_port;
      logic [15:0] owner_port;
   } rsp_item_type;

endpackage

@@ hw/rtl/spa_ram.sv @@
module spa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/session_port_allocator.sv @@
// Session port allocator: a table that binds server ports, taken from the
// inclusive range set in the range registers, to client ports.
// A request is a transfer on the command channel: it is taken at a rising
// edge with start high and busy low. Each request gives one result, shown
// on rsp_data for exactly one cycle while rsp_valid is high; the receiver
// cannot stall it, so it must take every result in that cycle.
// A request that fails at once (empty range on allocate, a port outside
// the range, an unused code) answers in the next cycle and keeps busy low.
// A lookup or free reads the memories in state S_LOOK, with busy high; its
// result is registered as it leaves S_LOOK, and no new request is taken
// before that. An allocate scans the occupancy bitmap one 32-slot word per
// cycle, stopping at the first word with a free slot in range; busy stays
// high for the scan. The bitmap memory has a registered read port.
// After reset the bitmap memory is cleared word by word in state S_CLEAR,
// during which busy is high; the range registers are written through the
// register port, and the user must write them only while no request is
// pending: the block itself does not enforce it.
module session_port_allocator #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Command channel.
   input  logic                  start,
   output logic                  busy,
   input  spa_pkg::req_item_type req_data,
   // Result channel.
   output logic                  rsp_valid,
   output spa_pkg::rsp_item_type rsp_data,
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int WORDS = (TABLE_SLOTS + spa_pkg::WORD_BITS - 1) / spa_pkg::WORD_BITS;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SW    = $clog2(TABLE_SLOTS);
   localparam int GW    = WW + spa_pkg::BIT_IDX_W;
   localparam int XW    = GW + 1;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_LOOK  = 2'd3;

   // Range registers.
   logic [15:0] range_low_ff, range_low_in;
   logic [15:0] range_high_ff, range_high_in;
   logic        csr_wr;

   // Control and latched request.
   logic [1:0]    state_ff, state_in;
   logic [WW-1:0] word_ff, word_in;
   logic [1:0]    op_ff, op_in;
   logic [15:0]   peer_ff, peer_in;
   logic [15:0]   port_ff, port_in;
   logic [GW-1:0] slot_ff, slot_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   spa_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                             bm_we;
   logic [WW-1:0]                    bm_waddr;
   logic [spa_pkg::WORD_BITS-1:0]    bm_wdata;
   logic [WW-1:0]                    bm_raddr;
   logic [spa_pkg::WORD_BITS-1:0]    bm_rdata;
   logic                             cl_we;
   logic [SW-1:0]                    cl_waddr;
   logic [15:0]                      cl_rdata;

   // Derived values.
   logic [16:0]                   span;
   logic [XW-1:0]                 usable;
   logic [15:0]                   offset;
   logic                          in_range;
   logic [XW-1:0]                 word_base;
   logic                          more_words;
   logic [spa_pkg::WORD_BITS-1:0] range_mask;
   logic [spa_pkg::WORD_BITS-1:0] free_bits;
   logic [spa_pkg::BIT_IDX_W-1:0] free_idx;
   logic [GW-1:0]                 alloc_slot;
   logic                          slot_bit;

   // ---------------------------------------------------------------------
   // Register port. Writes complete in the access phase; pready is tied high.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            spa_pkg::CSR_RANGE_LOW:  range_low_in  = csr_pwdata[15:0];
            spa_pkg::CSR_RANGE_HIGH: range_high_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         spa_pkg::CSR_RANGE_LOW:  csr_prdata = {16'd0, range_low_ff};
         spa_pkg::CSR_RANGE_HIGH: csr_prdata = {16'd0, range_high_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Usable range: the configured span clipped to the table size, or empty
   // when the high port lies below the low port.
   // ---------------------------------------------------------------------
   always_comb begin
      span = {1'b0, range_high_ff} - {1'b0, range_low_ff} + 17'd1;
      if (range_high_ff < range_low_ff) begin
         usable = '0;
      end else if (span > 17'(TABLE_SLOTS)) begin
         usable = XW'(TABLE_SLOTS);
      end else begin
         usable = span[XW-1:0];
      end
   end

   // Lookup and free: slot offset of the requested port and its range check.
   assign offset   = req_data.bound_port - range_low_ff;
   assign in_range = (req_data.bound_port >= range_low_ff) &&
                     ({1'b0, offset} < 17'(usable));

   // ---------------------------------------------------------------------
   // Allocation scan over the bitmap word read in the previous cycle.
   // Slots at or above the usable count are masked off.
   // ---------------------------------------------------------------------
   assign word_base  = XW'({word_ff, {spa_pkg::BIT_IDX_W{1'b0}}});
   assign more_words = (word_base + XW'(spa_pkg::WORD_BITS)) < usable;

   always_comb begin
      for (int j = 0; j < spa_pkg::WORD_BITS; j++) begin
         range_mask[j] = (word_base + XW'(j)) < usable;
      end
   end

   assign free_bits = ~bm_rdata & range_mask;

   // Lowest set bit of the free map.
   always_comb begin
      free_idx = '0;
      for (int j = spa_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            free_idx = spa_pkg::BIT_IDX_W'(j);
         end
      end
   end

   assign alloc_slot = {word_ff, free_idx};
   assign slot_bit   = bm_rdata[slot_ff[spa_pkg::BIT_IDX_W-1:0]];

   // Bitmap read address: the first word on an allocate, the addressed word
   // on a lookup or free, and the following word while the scan goes on.
   always_comb begin
      if (state_ff == S_SCAN) begin
         bm_raddr = more_words ? WW'(word_ff + 1'b1) : word_ff;
      end else if (req_data.req_type == spa_pkg::REQ_ALLOC) begin
         bm_raddr = '0;
      end else begin
         bm_raddr = offset[GW-1:spa_pkg::BIT_IDX_W];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      op_in        = op_ff;
      peer_in      = peer_ff;
      port_in      = port_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      bm_we        = 1'b0;
      bm_waddr     = word_ff;
      bm_wdata     = bm_rdata;
      cl_we        = 1'b0;
      cl_waddr     = alloc_slot[SW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            // Zero one bitmap word per cycle.
            bm_we    = 1'b1;
            bm_wdata = '0;
            word_in  = WW'(word_ff + 1'b1);
            if (word_ff == WW'(WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               op_in   = req_data.req_type;
               peer_in = req_data.peer_port;
               port_in = req_data.bound_port;
               slot_in = offset[GW-1:0];
               case (req_data.req_type)
                  spa_pkg::REQ_ALLOC: begin
                     if (usable == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: spa_pkg::STAT_FULL,
                                         granted_port: 16'd0, owner_port: 16'd0};
                     end else begin
                        word_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  spa_pkg::REQ_LOOKUP, spa_pkg::REQ_FREE: begin
                     if (in_range) begin
                        state_in = S_LOOK;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: spa_pkg::STAT_MISSING,
                                         granted_port: req_data.bound_port,
                                         owner_port: 16'd0};
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: spa_pkg::STAT_MISSING,
                                      granted_port: req_data.bound_port,
                                      owner_port: 16'd0};
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (free_bits != '0) begin
               // Claim the slot and record the client port.
               bm_we                   = 1'b1;
               bm_wdata                = bm_rdata;
               bm_wdata[free_idx]      = 1'b1;
               cl_we                   = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '{status: spa_pkg::STAT_OK,
                                           granted_port: range_low_ff + 16'(alloc_slot),
                                           owner_port: peer_ff};
               state_in                = S_IDLE;
            end else if (more_words) begin
               word_in = WW'(word_ff + 1'b1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: spa_pkg::STAT_FULL,
                                granted_port: 16'd0, owner_port: 16'd0};
               state_in     = S_IDLE;
            end
         end

         S_LOOK: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (slot_bit) begin
               rsp_data_in = '{status: spa_pkg::STAT_OK,
                               granted_port: port_ff, owner_port: cl_rdata};
               if (op_ff == spa_pkg::REQ_FREE) begin
                  bm_we                                        = 1'b1;
                  bm_waddr                                     = slot_ff[GW-1:spa_pkg::BIT_IDX_W];
                  bm_wdata                                     = bm_rdata;
                  bm_wdata[slot_ff[spa_pkg::BIT_IDX_W-1:0]]    = 1'b0;
               end
            end else begin
               rsp_data_in = '{status: spa_pkg::STAT_MISSING,
                               granted_port: port_ff, owner_port: 16'd0};
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         word_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         range_low_ff  <= spa_pkg::RANGE_LOW_RESET;
         range_high_ff <= spa_pkg::RANGE_HIGH_RESET;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         rsp_valid_ff  <= rsp_valid_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      peer_ff     <= peer_in;
      port_ff     <= port_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Memories: the occupancy bitmap, 32 slots per word, and the client
   // port of each slot.
   // ---------------------------------------------------------------------
   spa_ram #(
      .WIDTH (spa_pkg::WORD_BITS),
      .DEPTH (WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   spa_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_SLOTS)
   ) u_client_ram (
      .clock   (clock),
      .wr_en   (cl_we),
      .wr_addr (cl_waddr),
      .wr_data (peer_ff),
      .rd_addr (offset[SW-1:0]),
      .rd_data (cl_rdata)
   );

endmodule
